// ===== hdl/sdtq_pkg.sv =====
package sdtq_pkg;

   // Results per advance request before the walk stops.
   localparam int MAX_RESULTS = 16;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

   // Request operation codes.
   localparam logic [1:0] OP_SET     = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_CANCEL  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_EXPIRED = 2'd1;
   localparam logic [1:0] KIND_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] period;
      logic [15:0] timer_id;
      logic [7:0]  owner;
      logic [31:0] interval;
   } sdtq_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] expired_id;
      logic [7:0]  expired_owner;
      logic        last;
   } sdtq_rsp_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] timer_id;
      logic [7:0]  owner;
   } sdtq_entry_type;

   typedef struct packed {
      logic       latch;
      logic       rd_head;
      logic       rd_rptr;
      logic       add_elapsed;
      logic       ins_empty;
      logic       ins_front;
      logic       scan_start;
      logic       shift;
      logic       ins_place;
      logic       pop;
      logic       clear_all;
      logic       can_start;
      logic       can_step;
      logic       can_done;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_pend;
      logic       out_last;
   } sdtq_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       count_one;
      logic       owner_zero;
      logic       head_le;
      logic       scan_gt;
      logic       expired;
      logic       pend_valid;
      logic       n_last;
      logic       step_zero;
      logic       out_free;
   } sdtq_sts_type;

endpackage

// ===== hdl/sdtq_ram.sv =====
module sdtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sdtq_dpath.sv =====
module sdtq_dpath
   import sdtq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  sdtq_cmd_type cmd,
   output sdtq_sts_type sts,
   input  sdtq_req_type req_payload,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output sdtq_rsp_type rsp_payload
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = $bits(sdtq_entry_type);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   sdtq_req_type            req_ff, req_in;
   logic [31:0]             elapsed_ff, elapsed_in;
   logic [PW-1:0]           head_ff, head_in;
   logic [PW-1:0]           rptr_ff, rptr_in;
   logic [PW-1:0]           wptr_ff, wptr_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           step_ff, step_in;
   logic [CW-1:0]           kept_ff, kept_in;
   logic [RESULT_CNT_W-1:0] n_ff, n_in;
   logic                    pend_v_ff, pend_v_in;
   sdtq_entry_type          pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sdtq_rsp_type            rsp_ff, rsp_in;

   logic [ENTRY_W-1:0]      ram_rd_data;
   sdtq_entry_type          rdata;
   sdtq_entry_type          new_entry;
   sdtq_entry_type          wr_data;
   logic                    wr_en;
   logic [PW-1:0]           wr_addr;
   logic                    rd_en;
   logic [PW-1:0]           rd_addr;
   logic [CW:0]             tail_sum;
   logic [PW-1:0]           tail_ptr;
   logic                    keep;
   logic                    out_free;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == LAST_SLOT) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      ptr_dec = (p == '0) ? LAST_SLOT : p - PW'(1);
   endfunction

   assign rdata = sdtq_entry_type'(ram_rd_data);
   assign new_entry.deadline = req_ff.period + elapsed_ff;
   assign new_entry.timer_id = req_ff.timer_id;
   assign new_entry.owner = req_ff.owner;
   assign keep = rdata.owner != req_ff.owner;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Slot just past the youngest entry, modulo the ring size.
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_ptr = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                     PW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : PW'(tail_sum);

   assign rd_en = cmd.rd_head | cmd.rd_rptr;
   assign rd_addr = cmd.rd_head ? head_ff : rptr_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = wptr_ff;
      wr_data = rdata;
      if (cmd.ins_empty) begin
         wr_en = 1'b1;
         wr_addr = head_ff;
         wr_data.deadline = req_ff.period;
         wr_data.timer_id = req_ff.timer_id;
         wr_data.owner = req_ff.owner;
      end else if (cmd.ins_front) begin
         wr_en = 1'b1;
         wr_addr = ptr_dec(head_ff);
         wr_data = new_entry;
      end else if (cmd.ins_place) begin
         wr_en = 1'b1;
         wr_data = new_entry;
      end else if (cmd.shift) begin
         wr_en = 1'b1;
      end else if (cmd.can_step && keep) begin
         wr_en = 1'b1;
      end
   end

   sdtq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      req_in = req_ff;
      elapsed_in = elapsed_ff;
      head_in = head_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      count_in = count_ff;
      step_in = step_ff;
      kept_in = kept_ff;
      n_in = n_ff;
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;

      if (cmd.latch) begin
         req_in = req_payload;
      end
      if (cmd.add_elapsed) begin
         elapsed_in = elapsed_ff + req_ff.interval;
         n_in = '0;
         pend_v_in = 1'b0;
      end
      if (cmd.ins_empty) begin
         elapsed_in = '0;
         count_in = CW'(1);
      end
      if (cmd.ins_front) begin
         head_in = ptr_dec(head_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.ins_place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.scan_start) begin
         wptr_in = tail_ptr;
         rptr_in = ptr_dec(tail_ptr);
         step_in = count_ff;
      end
      if (cmd.shift) begin
         wptr_in = rptr_ff;
         rptr_in = ptr_dec(rptr_ff);
         step_in = step_ff - CW'(1);
      end
      if (cmd.pop) begin
         pend_in = rdata;
         pend_v_in = 1'b1;
         head_in = ptr_inc(head_ff);
         count_in = count_ff - CW'(1);
         n_in = n_ff + RESULT_CNT_W'(1);
      end
      if (cmd.clear_all) begin
         count_in = '0;
      end
      if (cmd.can_start) begin
         rptr_in = head_ff;
         wptr_in = head_ff;
         step_in = count_ff;
         kept_in = '0;
      end
      if (cmd.can_step) begin
         rptr_in = ptr_inc(rptr_ff);
         step_in = step_ff - CW'(1);
         if (keep) begin
            wptr_in = ptr_inc(wptr_ff);
            kept_in = kept_ff + CW'(1);
         end
      end
      if (cmd.can_done) begin
         count_in = kept_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.kind = cmd.out_kind;
         rsp_in.expired_id = cmd.out_pend ? pend_ff.timer_id : '0;
         rsp_in.expired_owner = cmd.out_pend ? pend_ff.owner : '0;
         rsp_in.last = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         head_ff <= '0;
         count_ff <= '0;
         pend_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         head_ff <= head_in;
         count_ff <= count_in;
         pend_v_ff <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      step_ff <= step_in;
      kept_ff <= kept_in;
      n_ff <= n_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign sts.op = req_ff.op;
   assign sts.empty = count_ff == '0;
   assign sts.full = count_ff == FULL_COUNT;
   assign sts.count_one = count_ff == CW'(1);
   assign sts.owner_zero = req_ff.owner == 8'd0;
   assign sts.head_le = new_entry.deadline <= rdata.deadline;
   assign sts.scan_gt = rdata.deadline > new_entry.deadline;
   assign sts.expired = rdata.deadline <= elapsed_ff;
   assign sts.pend_valid = pend_v_ff;
   assign sts.n_last = n_ff == RESULT_CNT_W'(MAX_RESULTS - 1);
   assign sts.step_zero = step_ff == '0;
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above queue depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from an empty queue");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (out_free && (!cmd.out_pend || pend_v_ff)))
      else $error("result loaded over a waiting result or without a pending entry");
`endif

endmodule

// ===== hdl/sdtq_ctrl.sv =====
module sdtq_ctrl
   import sdtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sdtq_sts_type sts,
   output sdtq_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_HCMP,
      ST_INS_RD,
      ST_INS_CMP,
      ST_ADV_RD,
      ST_ADV_CMP,
      ST_ADV_FIN,
      ST_CAN_RD,
      ST_CAN_CMP,
      ST_EMIT_ACK,
      ST_EMIT_FULL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.op)
               OP_SET: begin
                  if (sts.full) begin
                     state_in = ST_EMIT_FULL;
                  end else if (sts.empty) begin
                     cmd.ins_empty = 1'b1;
                     state_in = ST_EMIT_ACK;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in = ST_INS_HCMP;
                  end
               end
               OP_ADVANCE: begin
                  if (sts.empty) begin
                     state_in = ST_EMIT_ACK;
                  end else begin
                     cmd.add_elapsed = 1'b1;
                     cmd.rd_head = 1'b1;
                     state_in = ST_ADV_CMP;
                  end
               end
               OP_CANCEL: begin
                  if (sts.owner_zero) begin
                     cmd.clear_all = 1'b1;
                     state_in = ST_EMIT_ACK;
                  end else begin
                     cmd.can_start = 1'b1;
                     state_in = ST_CAN_RD;
                  end
               end
               default: begin
                  state_in = ST_EMIT_ACK;
               end
            endcase
         end
         ST_INS_HCMP: begin
            if (sts.head_le) begin
               cmd.ins_front = 1'b1;
               state_in = ST_EMIT_ACK;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            if (sts.step_zero) begin
               cmd.ins_place = 1'b1;
               state_in = ST_EMIT_ACK;
            end else begin
               cmd.rd_rptr = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (sts.scan_gt) begin
               cmd.shift = 1'b1;
               state_in = ST_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               state_in = ST_EMIT_ACK;
            end
         end
         ST_ADV_RD: begin
            cmd.rd_head = 1'b1;
            state_in = ST_ADV_CMP;
         end
         ST_ADV_CMP: begin
            if (sts.expired) begin
               if (!sts.pend_valid || sts.out_free) begin
                  cmd.pop = 1'b1;
                  if (sts.pend_valid) begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = KIND_EXPIRED;
                     cmd.out_pend = 1'b1;
                  end
                  if (sts.count_one || sts.n_last) begin
                     state_in = ST_ADV_FIN;
                  end else begin
                     state_in = ST_ADV_RD;
                  end
               end
            end else if (sts.pend_valid) begin
               state_in = ST_ADV_FIN;
            end else begin
               state_in = ST_EMIT_ACK;
            end
         end
         ST_ADV_FIN: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_EXPIRED;
               cmd.out_pend = 1'b1;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CAN_RD: begin
            if (sts.step_zero) begin
               cmd.can_done = 1'b1;
               state_in = ST_EMIT_ACK;
            end else begin
               cmd.rd_rptr = 1'b1;
               state_in = ST_CAN_CMP;
            end
         end
         ST_CAN_CMP: begin
            cmd.can_step = 1'b1;
            state_in = ST_CAN_RD;
         end
         ST_EMIT_ACK: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_ACK;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_FULL: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_FULL;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

`ifndef ASSERT_OFF
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) |=> state_ff == ST_IDLE)
      else $error("final result issued but request still active");
`endif

endmodule

// ===== hdl/sorted_deadline_timer_queue.sv =====
// One-shot timer queue kept in firing order by absolute deadline. A set
// request stores elapsed count plus period with the timer id and owner
// (the count is cleared first when the queue is empty); an equal or lower
// deadline than the current head goes in front, otherwise the entry lands
// after all entries due at or before it. An advance request adds its
// interval while the queue holds entries, then returns one expired result
// per due entry, earliest first, up to 16 per request, with last set on
// the final one; all other requests return one acknowledge (or a full
// flag for a rejected set). Entries live in a ring in a single-port-read
// RAM walked by a controller, one request at a time. A set that does not
// go to the head walks back from the tail; a cancel of one owner walks
// every queued entry, while a flush by owner zero clears the count. Each
// RAM step is a read followed by a compare and write. The next request is
// taken in the cycle after the final result loads, and a stalled waiting
// result delays that load. Counter and deadlines wrap at 32 bits and
// compare unsigned.
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sdtq_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sdtq_rsp_type rsp_payload
);

   sdtq_cmd_type cmd;
   sdtq_sts_type sts;

   // Sequence each request: decode, walk the ring, issue results.
   sdtq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // Hold the ring, pointers, elapsed count and the result register.
   sdtq_dpath #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_payload(req_payload),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule
